// File: hw/rtl/rle_xor_delta_pixel_decoder_assert.svh
// Assertion macros for the run-length XOR delta decoder.
`ifndef RLE_XOR_DELTA_PIXEL_DECODER_ASSERT_SVH
`define RLE_XOR_DELTA_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RXD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rxd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RXD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rxd assertion failed");

`endif

// File: hw/rtl/rxd_pkg.sv
// Package: constants and types of the run-length XOR delta decoder.
`default_nettype none
package rxd_pkg;

    localparam int FRAME_PIXELS_DEF = 76800;
    localparam int PIX_W            = 24;
    localparam int POS_OUT_W        = 17;
    localparam int CNT_W            = 3;
    localparam int SLOTS            = 4;
    localparam int IN_DATA_W        = 8;
    localparam int OUT_DATA_W       = 120;

    localparam logic [1:0] RUN_START = 2'd2;
    localparam logic [1:0] PHASE_LAST_BYTE = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_OUT   = 5'b10000
    } rxd_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rle_xor_delta_pixel_decoder.sv
// Top level: run-length decoder with XOR delta against a stored frame.
//
//  channel   dir  tdata (low bit up)                                 tlast       tuser
//  s_axis    in   in_byte[7:0]                                       frame_end   -
//  m_axis    out  pixel_a,pixel_b,pixel_c,pixel_d,pixel_count,       run_last    overflow
//                 first_position, zero fill to 120 bits
//
// After reset the frame store is swept to zero, with s_axis_tready low.
// A byte that does not finish a pixel is handled in ST_IDLE alone. A pixel byte gives
// its word after store read, XOR and write back; a run byte repeats store read, then
// XOR and write back through the single store port per pixel, up to four pixels per word.
// One byte is worked on at a time; a stall on m_axis holds the word and blocks input.
`default_nettype none
module rle_xor_delta_pixel_decoder #(
    parameter int FRAME_PIXELS = rxd_pkg::FRAME_PIXELS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [rxd_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // in_byte
    input  wire logic                            s_axis_tlast,   // frame_end
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // pixel_a, pixel_b, pixel_c, pixel_d, pixel_count, first_position
    output logic [rxd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tuser,   // overflow
    output logic                                 m_axis_tlast    // run_last
);
    import rxd_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_PIXELS);
    localparam int POS_W  = $clog2(FRAME_PIXELS + 1);
    localparam logic [POS_W-1:0]  POS_END  = POS_W'(FRAME_PIXELS);
    localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(FRAME_PIXELS - 1);

    logic [PIX_W-1:0] store [FRAME_PIXELS];

    rxd_state_t             state_reg, state_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [1:0]             phase_reg, phase_next;
    logic [15:0]            partial_reg, partial_next;
    logic [PIX_W-1:0]       ref_reg, ref_next;
    logic [1:0]             match_reg, match_next;
    logic                   fresh_reg, fresh_next;
    logic                   expect_reg, expect_next;
    logic                   last_reg, last_next;
    logic [PIX_W-1:0]       pix_reg, pix_next;
    logic [7:0]             left_reg, left_next;
    logic [1:0]             slot_reg, slot_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PIX_W-1:0]       slot_pix_reg [SLOTS];
    logic [PIX_W-1:0]       slot_pix_next [SLOTS];
    logic [POS_OUT_W-1:0]   first_reg, first_next;
    logic                   ovf_reg, ovf_next;
    logic                   tlast_reg, tlast_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    logic [PIX_W-1:0]       rdata_reg;

    logic                   at_end;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [PIX_W-1:0]       wr_data;
    logic [PIX_W-1:0]       px_full;
    logic [PIX_W-1:0]       px_val;
    logic [1:0]             match_inc;
    logic [31:0]            pos_wide;
    logic                   start_result;

    assign at_end    = (pos_reg >= POS_END);
    assign rd_addr   = at_end ? '0 : pos_reg[ADDR_W-1:0];
    assign px_full   = {partial_reg, s_axis_tdata};
    assign px_val    = at_end ? pix_reg : (pix_reg ^ rdata_reg);
    assign match_inc = match_reg + 2'd1;
    assign pos_wide  = 32'(pos_reg);

    // store port: zero sweep after reset, else read-modify-write of the current position
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            we      = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            we      = (state_reg == ST_WRITE) && !at_end;
            wr_addr = rd_addr;
            wr_data = px_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[wr_addr] <= wr_data;
        end
        rdata_reg <= store[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        ref_next     = ref_reg;
        match_next   = match_reg;
        fresh_next   = fresh_reg;
        expect_next  = expect_reg;
        last_next    = last_reg;
        pix_next     = pix_reg;
        left_next    = left_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        tlast_next   = tlast_reg;
        clr_next     = clr_reg;
        start_result = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_pix_next[i] = slot_pix_reg[i];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_TOP)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                    if (expect_reg)
                    begin
                        expect_next = 1'b0;
                        match_next  = '0;
                        fresh_next  = 1'b1;
                        if (s_axis_tdata != '0)
                        begin
                            pix_next     = ref_reg;
                            left_next    = s_axis_tdata;
                            start_result = 1'b1;
                        end
                    end
                    else if (phase_reg != PHASE_LAST_BYTE)
                    begin
                        partial_next = {partial_reg[7:0], s_axis_tdata};
                        phase_next   = phase_reg + 2'd1;
                    end
                    else
                    begin
                        ref_next     = px_full;
                        fresh_next   = 1'b0;
                        phase_next   = '0;
                        partial_next = '0;
                        pix_next     = px_full;
                        left_next    = 8'd1;
                        start_result = 1'b1;
                        if (fresh_reg || (px_full == ref_reg))
                        begin
                            match_next = match_inc;
                            if ((match_inc == RUN_START) && !s_axis_tlast)
                            begin
                                expect_next = 1'b1;
                            end
                        end
                        else
                        begin
                            match_next = '0;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        phase_next   = '0;
                        partial_next = '0;
                        match_next   = '0;
                        fresh_next   = 1'b1;
                        expect_next  = 1'b0;
                        // nothing to emit: the frame closes at once
                        if (!start_result)
                        begin
                            pos_next = '0;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                slot_pix_next[slot_reg] = px_val;
                count_next = count_reg + 1'b1;
                left_next  = left_reg - 8'd1;
                if (at_end)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if ((left_reg == 8'd1) || (slot_reg == 2'd3))
                begin
                    tlast_next = (left_reg == 8'd1);
                    state_next = ST_OUT;
                end
                else
                begin
                    slot_next  = slot_reg + 2'd1;
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    if (left_reg != '0)
                    begin
                        start_result = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (last_reg)
                        begin
                            pos_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_result)
        begin
            state_next = ST_READ;
            slot_next  = '0;
            count_next = '0;
            first_next = pos_wide[POS_OUT_W-1:0];
            ovf_next   = 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_pix_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            pos_reg    <= '0;
            phase_reg  <= '0;
            partial_reg <= '0;
            ref_reg    <= '0;
            match_reg  <= '0;
            fresh_reg  <= 1'b1;
            expect_reg <= 1'b0;
            last_reg   <= 1'b0;
            left_reg   <= '0;
            slot_reg   <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            partial_reg <= partial_next;
            ref_reg    <= ref_next;
            match_reg  <= match_next;
            fresh_reg  <= fresh_next;
            expect_reg <= expect_next;
            last_reg   <= last_next;
            left_reg   <= left_next;
            slot_reg   <= slot_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        count_reg <= count_next;
        first_reg <= first_next;
        ovf_reg   <= ovf_next;
        tlast_reg <= tlast_next;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_pix_reg[i] <= slot_pix_next[i];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {4'b0, first_reg, count_reg, slot_pix_reg[3], slot_pix_reg[2],
                            slot_pix_reg[1], slot_pix_reg[0]};
    assign m_axis_tuser  = ovf_reg;
    assign m_axis_tlast  = tlast_reg;

`include "rle_xor_delta_pixel_decoder_assert.svh"

    `RXD_ASSERT_NOW(a_count_range, clk, rst_n, m_axis_tvalid, (count_reg != '0) && (count_reg <= 3'd4))
    `RXD_ASSERT_NOW(a_run_word_full, clk, rst_n, m_axis_tvalid && !m_axis_tlast, count_reg == 3'd4)
    `RXD_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, pos_reg <= POS_END)
    `RXD_ASSERT_NOW(a_no_write_past_end, clk, rst_n, state_reg == ST_WRITE, we == !at_end)
    `RXD_ASSERT_NEXT(a_write_advances, clk, rst_n, (state_reg == ST_WRITE) && !at_end, pos_reg == $past(pos_reg) + 1'b1)

endmodule
`default_nettype wire
